// ===== rtl/vdic_pkg.sv =====
package vdic_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int STEP_W     = 17;
    localparam int BOUND_W    = 31;
    localparam int MASS_W     = 31;
    localparam int DT2_W      = 2 * STEP_W - FRAC_BITS;
    localparam int PROD_MAG_W = MASS_W + DT2_W;
    localparam int SQ_IN_W    = 64;
    localparam int SQ_OUT_W   = 32;
    localparam int SQ_REM_W   = 36;
    localparam int DIV_STAGES = PROD_MAG_W;
    localparam int PAD_STAGES = DIV_STAGES - SQ_OUT_W;
    localparam int LATENCY    = DIV_STAGES + 7;

    localparam logic [STEP_W-1:0]  TIME_STEP_RST = STEP_W'(137);
    localparam logic [STEP_W-1:0]  DRAG_COEF_RST = STEP_W'(3277);
    localparam logic [BOUND_W-1:0] BOUND_MAX_RST = BOUND_W'(67043328);

    typedef enum logic [1:0] {
        REG_TIME_STEP,
        REG_DRAG_COEF,
        REG_BOUND_MAX_X,
        REG_BOUND_MAX_Y
    } cfg_index_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] old_x;
        logic signed [DATA_W-1:0] old_y;
        logic signed [DATA_W-1:0] acc_x;
        logic signed [DATA_W-1:0] acc_y;
        logic        [MASS_W-1:0] mass;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] new_x;
        logic signed [DATA_W-1:0] new_y;
        logic signed [DATA_W-1:0] prev_x;
        logic signed [DATA_W-1:0] prev_y;
        logic                     mass_zero;
    } result_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] vx;
        logic signed [DATA_W-1:0] vy;
        logic                     mzero;
        logic                     negx;
        logic                     negy;
    } side_t;

    function automatic logic signed [63:0] sext64(input logic signed [DATA_W-1:0] x);
        return $signed({{(64 - DATA_W){x[DATA_W-1]}}, x});
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = $signed(64'h0000_0000_7FFF_FFFF);
        lo = $signed(64'hFFFF_FFFF_8000_0000);
        if (x > hi)
            return hi[DATA_W-1:0];
        else if (x < lo)
            return lo[DATA_W-1:0];
        else
            return x[DATA_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_box(input logic signed [63:0] x,
                                                           input logic [BOUND_W-1:0] hi);
        logic signed [63:0] hi_s;
        hi_s = $signed({{(64 - BOUND_W){1'b0}}, hi});
        if (x[63])
            return '0;
        else if (x > hi_s)
            return hi_s[DATA_W-1:0];
        else
            return x[DATA_W-1:0];
    endfunction

endpackage

// ===== rtl/vdic_sqrt.sv =====
module vdic_sqrt import vdic_pkg::*;
(
    input  logic                clk,
    input  logic                adv,
    input  logic [SQ_IN_W-1:0]  radicand,
    output logic [SQ_OUT_W-1:0] root
);

    logic [SQ_REM_W-1:0] rem_reg  [SQ_OUT_W];
    logic [SQ_OUT_W-1:0] root_reg [SQ_OUT_W];
    logic [SQ_IN_W-1:0]  rad_reg  [SQ_OUT_W];

    for (genvar i = 0; i < SQ_OUT_W; i++) begin : g_stage
        logic [SQ_REM_W-1:0] rem_in;
        logic [SQ_OUT_W-1:0] root_in;
        logic [SQ_IN_W-1:0]  rad_in;
        logic [SQ_REM_W-1:0] trial_rem;
        logic [SQ_REM_W-1:0] trial;
        logic [SQ_REM_W-1:0] rem_next;
        logic [SQ_OUT_W-1:0] root_next;
        logic [SQ_IN_W-1:0]  rad_next;

        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
        end
        else begin : g_rest
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rad_in  = rad_reg[i-1];
        end

        assign trial_rem = {rem_in[SQ_REM_W-3:0], rad_in[SQ_IN_W-1 -: 2]};
        assign trial     = SQ_REM_W'({root_in, 2'b01});

        always_comb
        begin
            if (trial_rem >= trial)
            begin
                rem_next  = trial_rem - trial;
                root_next = {root_in[SQ_OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial_rem;
                root_next = {root_in[SQ_OUT_W-2:0], 1'b0};
            end
            rad_next = {rad_in[SQ_IN_W-3:0], 2'b00};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                rad_reg[i]  <= rad_next;
            end
        end
    end

    assign root = root_reg[SQ_OUT_W-1];

endmodule

// ===== rtl/vdic_div.sv =====
module vdic_div import vdic_pkg::*;
(
    input  logic                  clk,
    input  logic                  adv,
    input  logic [PROD_MAG_W-1:0] dividend,
    input  logic [MASS_W-1:0]     divisor,
    output logic [PROD_MAG_W-1:0] quotient
);

    logic [MASS_W-1:0]     rem_reg [DIV_STAGES];
    logic [PROD_MAG_W-1:0] quo_reg [DIV_STAGES];
    logic [PROD_MAG_W-1:0] dnd_reg [DIV_STAGES];
    logic [MASS_W-1:0]     dvs_reg [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
        logic [MASS_W-1:0]     rem_in;
        logic [PROD_MAG_W-1:0] quo_in;
        logic [PROD_MAG_W-1:0] dnd_in;
        logic [MASS_W-1:0]     dvs_in;
        logic [MASS_W:0]       trial;
        logic [MASS_W-1:0]     rem_next;
        logic [PROD_MAG_W-1:0] quo_next;

        if (i == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
            assign dnd_in = dividend;
            assign dvs_in = divisor;
        end
        else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign dnd_in = dnd_reg[i-1];
            assign dvs_in = dvs_reg[i-1];
        end

        assign trial = {rem_in, dnd_in[PROD_MAG_W-1]};

        always_comb
        begin
            if (trial >= {1'b0, dvs_in})
            begin
                rem_next = MASS_W'(trial - {1'b0, dvs_in});
                quo_next = {quo_in[PROD_MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[MASS_W-1:0];
                quo_next = {quo_in[PROD_MAG_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i] <= rem_next;
                quo_reg[i] <= quo_next;
                dnd_reg[i] <= {dnd_in[PROD_MAG_W-2:0], 1'b0};
                dvs_reg[i] <= dvs_in;
            end
        end
    end

    assign quotient = quo_reg[DIV_STAGES-1];

endmodule

// ===== rtl/verlet_drag_integrate_clamp_unit.sv =====
// Each accepted transaction passes through velocity, force products and magnitudes, then the
// one-bit-per-stage acceleration divider with the square root beside it, then drag and clamp.
// Throughput: one transaction per cycle; the whole pipeline holds while the result is stalled.
// Reset: rst_n clears all valid bits and loads the register defaults; no clearing pass.
module verlet_drag_integrate_clamp_unit import vdic_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  item_t              item,
    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result,
    input  logic               wr_en,
    input  logic [1:0]         wr_index,
    input  logic [BOUND_W-1:0] wr_data
);

    logic [STEP_W-1:0]  time_step_reg;
    logic [STEP_W-1:0]  drag_coef_reg;
    logic [BOUND_W-1:0] bound_max_x_reg;
    logic [BOUND_W-1:0] bound_max_y_reg;
    logic [DT2_W-1:0]   dt2_reg;
    logic [DT2_W-1:0]   k_reg;
    logic [2*STEP_W-1:0] dt2_full;
    logic [2*STEP_W-1:0] k_full;

    logic [LATENCY-1:0] vld_reg;
    logic               adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg   <= TIME_STEP_RST;
            drag_coef_reg   <= DRAG_COEF_RST;
            bound_max_x_reg <= BOUND_MAX_RST;
            bound_max_y_reg <= BOUND_MAX_RST;
        end
        else if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_TIME_STEP:   time_step_reg   <= wr_data[STEP_W-1:0];
                REG_DRAG_COEF:   drag_coef_reg   <= wr_data[STEP_W-1:0];
                REG_BOUND_MAX_X: bound_max_x_reg <= wr_data;
                REG_BOUND_MAX_Y: bound_max_y_reg <= wr_data;
                default: ;
            endcase
        end
    end

    assign dt2_full = time_step_reg * time_step_reg;
    assign k_full   = drag_coef_reg * time_step_reg;

    always_ff @(posedge clk)
    begin
        dt2_reg <= dt2_full[2*STEP_W-1:FRAC_BITS];
        k_reg   <= k_full[2*STEP_W-1:FRAC_BITS];
    end

    assign adv          = !vld_reg[LATENCY-1] || !result_stall;
    assign item_stall   = !adv;
    assign result_valid = vld_reg[LATENCY-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LATENCY-2:0], item_valid};
    end

    // velocity
    logic signed [DATA_W-1:0] s1_px_reg, s1_py_reg, s1_vx_reg, s1_vy_reg;
    logic signed [DATA_W-1:0] s1_ax_reg, s1_ay_reg;
    logic [MASS_W-1:0]        s1_m_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_px_reg <= item.pos_x;
            s1_py_reg <= item.pos_y;
            s1_vx_reg <= sat32(sext64(item.pos_x) - sext64(item.old_x));
            s1_vy_reg <= sat32(sext64(item.pos_y) - sext64(item.old_y));
            s1_ax_reg <= item.acc_x;
            s1_ay_reg <= item.acc_y;
            s1_m_reg  <= item.mass;
        end
    end

    // squares and force products
    logic signed [63:0]         s2_sqx_next, s2_sqy_next;
    logic signed [PROD_MAG_W:0] s2_prx_next, s2_pry_next;
    logic signed [63:0]         s2_sqx_reg, s2_sqy_reg;
    logic signed [PROD_MAG_W:0] s2_prx_reg, s2_pry_reg;
    logic signed [DATA_W-1:0]   s2_px_reg, s2_py_reg, s2_vx_reg, s2_vy_reg;
    logic [MASS_W-1:0]          s2_m_reg;

    assign s2_sqx_next = s1_vx_reg * s1_vx_reg;
    assign s2_sqy_next = s1_vy_reg * s1_vy_reg;
    assign s2_prx_next = s1_ax_reg * $signed({1'b0, dt2_reg});
    assign s2_pry_next = s1_ay_reg * $signed({1'b0, dt2_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_sqx_reg <= s2_sqx_next;
            s2_sqy_reg <= s2_sqy_next;
            s2_prx_reg <= s2_prx_next;
            s2_pry_reg <= s2_pry_next;
            s2_px_reg  <= s1_px_reg;
            s2_py_reg  <= s1_py_reg;
            s2_vx_reg  <= s1_vx_reg;
            s2_vy_reg  <= s1_vy_reg;
            s2_m_reg   <= s1_m_reg;
        end
    end

    // speed squared and dividend magnitudes
    logic [SQ_IN_W-1:0]    s3_sq_reg;
    logic [PROD_MAG_W-1:0] s3_magx_reg, s3_magy_reg;
    logic [MASS_W-1:0]     s3_m_reg;
    side_t                 s3_side_reg;
    logic [PROD_MAG_W:0]   s3_negprx, s3_negpry;

    assign s3_negprx = -s2_prx_reg;
    assign s3_negpry = -s2_pry_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_sq_reg         <= $unsigned(s2_sqx_reg) + $unsigned(s2_sqy_reg);
            s3_magx_reg       <= s2_prx_reg[PROD_MAG_W] ? s3_negprx[PROD_MAG_W-1:0]
                                                        : s2_prx_reg[PROD_MAG_W-1:0];
            s3_magy_reg       <= s2_pry_reg[PROD_MAG_W] ? s3_negpry[PROD_MAG_W-1:0]
                                                        : s2_pry_reg[PROD_MAG_W-1:0];
            s3_m_reg          <= s2_m_reg;
            s3_side_reg.px    <= s2_px_reg;
            s3_side_reg.py    <= s2_py_reg;
            s3_side_reg.vx    <= s2_vx_reg;
            s3_side_reg.vy    <= s2_vy_reg;
            s3_side_reg.mzero <= (s2_m_reg == '0);
            s3_side_reg.negx  <= s2_prx_reg[PROD_MAG_W];
            s3_side_reg.negy  <= s2_pry_reg[PROD_MAG_W];
        end
    end

    logic [SQ_OUT_W-1:0]   sq_root;
    logic [PROD_MAG_W-1:0] quo_x, quo_y;

    vdic_sqrt u_sqrt
    (
        .clk      (clk),
        .adv      (adv),
        .radicand (s3_sq_reg),
        .root     (sq_root)
    );

    vdic_div u_div_x
    (
        .clk      (clk),
        .adv      (adv),
        .dividend (s3_magx_reg),
        .divisor  (s3_m_reg),
        .quotient (quo_x)
    );

    vdic_div u_div_y
    (
        .clk      (clk),
        .adv      (adv),
        .dividend (s3_magy_reg),
        .divisor  (s3_m_reg),
        .quotient (quo_y)
    );

    side_t               side_reg [DIV_STAGES];
    logic [SQ_OUT_W-1:0] len_reg  [PAD_STAGES];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= s3_side_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                side_reg[i] <= side_reg[i-1];
            len_reg[0] <= sq_root;
            for (int i = 1; i < PAD_STAGES; i++)
                len_reg[i] <= len_reg[i-1];
        end
    end

    // drag factor and acceleration terms
    side_t                    side_out;
    logic [SQ_OUT_W+DT2_W-1:0] s4_tfull;
    logic [SQ_OUT_W+DT2_W-1:0] s4_tsh;
    logic [DATA_W-2:0]        s4_t_next;
    logic signed [63:0]       s4_gx64, s4_gy64;
    logic [DATA_W-2:0]        s4_t_reg;
    logic signed [DATA_W-1:0] s4_gx_reg, s4_gy_reg;
    side_t                    s4_side_reg;

    assign side_out = side_reg[DIV_STAGES-1];
    assign s4_tfull = len_reg[PAD_STAGES-1] * k_reg;
    assign s4_tsh   = s4_tfull >> FRAC_BITS;
    assign s4_t_next = (s4_tsh > (SQ_OUT_W+DT2_W)'(32'h7FFF_FFFF)) ? {(DATA_W-1){1'b1}}
                                                                  : s4_tsh[DATA_W-2:0];
    assign s4_gx64 = side_out.negx ? -$signed(64'(quo_x)) : $signed(64'(quo_x));
    assign s4_gy64 = side_out.negy ? -$signed(64'(quo_y)) : $signed(64'(quo_y));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_t_reg    <= s4_t_next;
            s4_gx_reg   <= side_out.mzero ? '0 : sat32(s4_gx64);
            s4_gy_reg   <= side_out.mzero ? '0 : sat32(s4_gy64);
            s4_side_reg <= side_out;
        end
    end

    // drag products
    logic signed [63:0]       s5_dpx_next, s5_dpy_next;
    logic signed [63:0]       s5_dpx_reg, s5_dpy_reg;
    logic signed [DATA_W-1:0] s5_gx_reg, s5_gy_reg;
    side_t                    s5_side_reg;

    assign s5_dpx_next = s4_side_reg.vx * $signed({1'b0, s4_t_reg});
    assign s5_dpy_next = s4_side_reg.vy * $signed({1'b0, s4_t_reg});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_dpx_reg  <= s5_dpx_next;
            s5_dpy_reg  <= s5_dpy_next;
            s5_gx_reg   <= s4_gx_reg;
            s5_gy_reg   <= s4_gy_reg;
            s5_side_reg <= s4_side_reg;
        end
    end

    // drag applied to velocity
    logic [63:0]              s6_magx, s6_magy;
    logic signed [63:0]       s6_dx, s6_dy;
    logic signed [DATA_W-1:0] s6_nvx_reg, s6_nvy_reg;
    logic signed [DATA_W-1:0] s6_gx_reg, s6_gy_reg;
    side_t                    s6_side_reg;

    assign s6_magx = s5_dpx_reg[63] ? $unsigned(-s5_dpx_reg) : $unsigned(s5_dpx_reg);
    assign s6_magy = s5_dpy_reg[63] ? $unsigned(-s5_dpy_reg) : $unsigned(s5_dpy_reg);
    assign s6_dx   = s5_dpx_reg[63] ? -$signed(s6_magx >> FRAC_BITS)
                                    : $signed(s6_magx >> FRAC_BITS);
    assign s6_dy   = s5_dpy_reg[63] ? -$signed(s6_magy >> FRAC_BITS)
                                    : $signed(s6_magy >> FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_nvx_reg  <= sat32(sext64(s5_side_reg.vx) - s6_dx);
            s6_nvy_reg  <= sat32(sext64(s5_side_reg.vy) - s6_dy);
            s6_gx_reg   <= s5_gx_reg;
            s6_gy_reg   <= s5_gy_reg;
            s6_side_reg <= s5_side_reg;
        end
    end

    // integrate and clamp
    logic signed [63:0] s7_sumx, s7_sumy;
    result_t            result_reg;

    assign s7_sumx = sext64(s6_side_reg.px) + sext64(s6_nvx_reg) + sext64(s6_gx_reg);
    assign s7_sumy = sext64(s6_side_reg.py) + sext64(s6_nvy_reg) + sext64(s6_gy_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_reg.new_x     <= clamp_box(s7_sumx, bound_max_x_reg);
            result_reg.new_y     <= clamp_box(s7_sumy, bound_max_y_reg);
            result_reg.prev_x    <= clamp_box(sext64(s6_side_reg.px), bound_max_x_reg);
            result_reg.prev_y    <= clamp_box(sext64(s6_side_reg.py), bound_max_y_reg);
            result_reg.mass_zero <= s6_side_reg.mzero;
        end
    end

    assign result = result_reg;

endmodule

// ===== rtl/vdic_checker.sv =====
module vdic_checker import vdic_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // input holds only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("input stalled without a stalled result");

    // positions never fall below the lower edge of the box (zero)
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!result.new_x[DATA_W-1] && !result.new_y[DATA_W-1]
                          && !result.prev_x[DATA_W-1] && !result.prev_y[DATA_W-1]))
        else $error("result position below zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> $stable(result))
        else $error("stalled result changed");

endmodule

bind verlet_drag_integrate_clamp_unit vdic_checker u_checker (.*);
